### sv/fgsr_pkg.sv
// ----------------------------------------------------------------------------
// fgsr_pkg
// Types and constants shared by the feed gap / snapshot recovery block.
// ----------------------------------------------------------------------------
`default_nettype none

package fgsr_pkg;

	// configuration register indexes
	localparam logic [1:0] CFG_START_SEQ  = 2'd0;
	localparam logic [1:0] CFG_START_CODE = 2'd1;
	localparam logic [1:0] CFG_END_CODE   = 2'd2;

	localparam logic [31:0] START_SEQ_RST  = 32'd0;
	localparam logic [3:0]  START_CODE_RST = 4'd1;
	localparam logic [3:0]  END_CODE_RST   = 4'd2;

	typedef struct packed {
		logic        from_snapshot;
		logic [31:0] seq_num;
		logic [3:0]  msg_type;
		logic [31:0] ord_ref;
		logic [63:0] payload;
	} in_t;

	typedef struct packed {
		logic [3:0]  out_type;
		logic [31:0] out_ord_ref;
		logic [63:0] out_payload;
		logic        from_replay;
		logic        last_of_run;
	} out_t;

	typedef struct packed {
		logic [3:0]  msg_type;
		logic [31:0] ord_ref;
		logic [63:0] payload;
	} snap_ent_t;

	typedef struct packed {
		logic [31:0] tag;
		logic [3:0]  msg_type;
		logic [31:0] ord_ref;
		logic [63:0] payload;
	} inc_ent_t;

	// request from the sequencer to the output stage
	typedef struct packed {
		logic push;   // item offered
		logic last;   // item closes its run on its own (live beat)
		logic flush;  // close the held beat as last of run
	} oreq_t;

endpackage

`default_nettype wire

### sv/fgsr_out.sv
// ----------------------------------------------------------------------------
// fgsr_out
// Output register with a one-beat lookahead hold, so that last_of_run can be
// set on the final beat of a replay run.
// ----------------------------------------------------------------------------
`default_nettype none

module fgsr_out
	import fgsr_pkg::*;
(
	input  wire   clk,
	input  wire   arst_n,
	input  oreq_t req,
	input  out_t  item,
	output logic  ready,
	output logic  out_valid,
	input  wire   out_stall,
	output out_t  out
);

	logic out_v_q;
	out_t out_q;
	logic pend_v_q;
	out_t pend_q;

	logic load;
	out_t load_d;

	assign ready     = !out_v_q || !out_stall;
	assign out_valid = out_v_q;
	assign out       = out_q;

	always_comb begin
		load   = 1'b0;
		load_d = item;
		if (req.push) begin
			if (req.last) begin
				load                = 1'b1;
				load_d              = item;
				load_d.last_of_run  = 1'b1;
			end else if (pend_v_q) begin
				load                = 1'b1;
				load_d              = pend_q;
				load_d.last_of_run  = 1'b0;
			end
		end else if (req.flush && pend_v_q) begin
			load               = 1'b1;
			load_d             = pend_q;
			load_d.last_of_run = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			pend_v_q <= 1'b0;
		end else if (ready) begin
			out_v_q <= load;
			if (req.push && !req.last)
				pend_v_q <= 1'b1;
			else if (!req.push && req.flush)
				pend_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && load)
			out_q <= load_d;
		if (ready && req.push && !req.last)
			pend_q <= item;
	end

endmodule

`default_nettype wire

### sv/feed_gap_snapshot_recovery_core.sv
// ----------------------------------------------------------------------------
// feed_gap_snapshot_recovery_core
// Sequence gap detector with snapshot recovery for a decoded market-data feed.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall / in): one decoded message per beat.
// Output channel (out_valid / out_stall / out): forwarded updates; the last
// beat caused by a message carries last_of_run.
// Config port (cfg_we / cfg_index / cfg_data): start sequence and the two
// snapshot marker codes; write only while the block is idle.
// In-order live messages are written into the output register as they are
// taken, one message per cycle while the output drains.
// In recovery each message is buffered and the stores are checked:
// an incremental first scans the incremental memory and writes its slot,
// the snapshot valid bits are walked, then each step of the incremental walk
// is one full memory scan (one per replayed incremental, plus one closing
// scan), and replay reads each snapshot entry and rescans the incremental
// memory for each incremental. in_stall stays high throughout.
// Reset clears recovery, the store valid bits and the sticky overflow flag;
// no clearing pass is needed. A stalled receiver holds the output register
// and the sequencer waits on it.
// ----------------------------------------------------------------------------
`default_nettype none

module feed_gap_snapshot_recovery_core
	import fgsr_pkg::*;
#(
	parameter int SNAP_DEPTH = 32,
	parameter int INC_DEPTH  = 32
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  in_t         in,
	output logic        out_valid,
	input  wire         out_stall,
	output out_t        out,
	input  wire         cfg_we,
	input  wire  [1:0]  cfg_index,
	input  wire  [31:0] cfg_data
);

	localparam int SAW = $clog2(SNAP_DEPTH);
	localparam int IAW = $clog2(INC_DEPTH);
	localparam int SCW = $clog2(SNAP_DEPTH + 1);
	localparam int ICW = $clog2(INC_DEPTH + 1);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_IFIND  = 4'd1;
	localparam logic [3:0] ST_IWR    = 4'd2;
	localparam logic [3:0] ST_SSCAN  = 4'd3;
	localparam logic [3:0] ST_SRD0   = 4'd4;
	localparam logic [3:0] ST_SCHK0  = 4'd5;
	localparam logic [3:0] ST_SCHKN  = 4'd6;
	localparam logic [3:0] ST_WALK   = 4'd7;
	localparam logic [3:0] ST_WDEC   = 4'd8;
	localparam logic [3:0] ST_RSRD   = 4'd9;
	localparam logic [3:0] ST_RSCHK  = 4'd10;
	localparam logic [3:0] ST_RINC   = 4'd11;
	localparam logic [3:0] ST_RIPUSH = 4'd12;
	localparam logic [3:0] ST_FIN    = 4'd13;

	logic [3:0]  state_q;
	logic        rec_q;
	logic        ovf_q;
	logic [31:0] exp_q;
	logic [3:0]  start_code_q;
	logic [3:0]  end_code_q;

	logic [SNAP_DEPTH-1:0] snap_valid_q;
	logic [INC_DEPTH-1:0]  inc_valid_q;

	snap_ent_t snap_mem [SNAP_DEPTH];
	inc_ent_t  inc_mem  [INC_DEPTH];
	snap_ent_t snap_rd_q;
	inc_ent_t  inc_rd_q;

	logic            snap_we, snap_re;
	logic [SAW-1:0]  snap_wa, snap_ra;
	snap_ent_t       snap_wd;
	logic            inc_we, inc_re;
	logic [IAW-1:0]  inc_wa;
	inc_ent_t        inc_wd;

	in_t             item_q;
	// incremental scan engine
	logic [ICW-1:0]  sc_q;
	logic            rv_s1;
	logic [IAW-1:0]  ridx_s1;
	logic            hit_q, free_q;
	logic [IAW-1:0]  slot_q, fslot_q;
	// snapshot valid walk
	logic [SCW-1:0]  si_q, n_q, ri_q;
	logic            any_q, hole_q, gap_q;
	// incremental walk / replay
	logic [31:0]     next_q, start_q, rnext_q;
	logic [ICW-1:0]  nsel_q;
	logic            eq_q, eqm_q, gt_q;
	inc_ent_t        hit_ent_q;

	logic  acc, scanning, issue, scan_end, ev;
	logic  oready;
	oreq_t oreq;
	out_t  oitem;

	function automatic logic is_marker(input logic [3:0] t, input logic [3:0] sc,
		input logic [3:0] ec);
		return (t == sc) || (t == ec);
	endfunction

	assign acc      = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE) || !oready;
	assign scanning = (state_q == ST_IFIND) || (state_q == ST_WALK) || (state_q == ST_RINC);
	assign issue    = scanning && (sc_q < ICW'(INC_DEPTH));
	assign scan_end = scanning && !issue && !rv_s1;
	assign ev       = rv_s1 && inc_valid_q[ridx_s1];

	// memory port control
	always_comb begin
		snap_we = 1'b0;
		snap_wa = in.seq_num[SAW-1:0];
		snap_wd = snap_ent_t'{in.msg_type, in.ord_ref, in.payload};
		snap_re = 1'b0;
		snap_ra = '0;
		inc_we  = (state_q == ST_IWR) && (hit_q || free_q);
		inc_wa  = hit_q ? slot_q : fslot_q;
		inc_wd  = inc_ent_t'{item_q.seq_num, item_q.msg_type, item_q.ord_ref,
			item_q.payload};
		inc_re  = issue;
		if (acc && in.from_snapshot && rec_q && (in.seq_num < 32'(SNAP_DEPTH)))
			snap_we = 1'b1;
		case (state_q)
			ST_SRD0: begin
				snap_re = 1'b1;
			end
			ST_SCHK0: begin
				snap_re = 1'b1;
				snap_ra = SAW'(n_q - SCW'(1));
			end
			ST_RSRD: begin
				snap_re = (ri_q != n_q);
				snap_ra = ri_q[SAW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (snap_we)
			snap_mem[snap_wa] <= snap_wd;
		if (snap_re)
			snap_rd_q <= snap_mem[snap_ra];
		if (inc_we)
			inc_mem[inc_wa] <= inc_wd;
		if (inc_re)
			inc_rd_q <= inc_mem[sc_q[IAW-1:0]];
	end

	// output requests
	always_comb begin
		oreq  = '0;
		oitem = '0;
		case (state_q)
			ST_IDLE: begin
				oitem = out_t'{in.msg_type, in.ord_ref, in.payload, 1'b0, 1'b1};
				if (acc && !in.from_snapshot && !rec_q && in.seq_num == exp_q) begin
					oreq.push = 1'b1;
					oreq.last = 1'b1;
				end
			end
			ST_RSCHK: begin
				oitem = out_t'{snap_rd_q.msg_type, snap_rd_q.ord_ref, snap_rd_q.payload,
					1'b1, 1'b0};
				oreq.push = !is_marker(snap_rd_q.msg_type, start_code_q, end_code_q);
			end
			ST_RIPUSH: begin
				oitem = out_t'{hit_ent_q.msg_type, hit_ent_q.ord_ref, hit_ent_q.payload,
					1'b1, 1'b0};
				oreq.push = 1'b1;
			end
			ST_FIN: begin
				oreq.flush = 1'b1;
			end
			default: begin
			end
		endcase
	end

	fgsr_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (oreq),
		.item      (oitem),
		.ready     (oready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out       (out)
	);

	// scan pipeline stage and captured entries (payload side)
	always_ff @(posedge clk) begin
		if (acc)
			item_q <= in;
		ridx_s1 <= sc_q[IAW-1:0];
		if (state_q == ST_IFIND && ev && inc_rd_q.tag == item_q.seq_num)
			slot_q <= ridx_s1;
		if (state_q == ST_IFIND && rv_s1 && !inc_valid_q[ridx_s1] && !free_q)
			fslot_q <= ridx_s1;
		if (state_q == ST_RINC && ev && inc_rd_q.tag == rnext_q)
			hit_ent_q <= inc_rd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			rec_q        <= 1'b0;
			ovf_q        <= 1'b0;
			exp_q        <= START_SEQ_RST;
			start_code_q <= START_CODE_RST;
			end_code_q   <= END_CODE_RST;
			snap_valid_q <= '0;
			inc_valid_q  <= '0;
			sc_q         <= '0;
			rv_s1        <= 1'b0;
			hit_q        <= 1'b0;
			free_q       <= 1'b0;
			si_q         <= '0;
			n_q          <= '0;
			ri_q         <= '0;
			any_q        <= 1'b0;
			hole_q       <= 1'b0;
			gap_q        <= 1'b0;
			next_q       <= '0;
			start_q      <= '0;
			rnext_q      <= '0;
			nsel_q       <= '0;
			eq_q         <= 1'b0;
			eqm_q        <= 1'b0;
			gt_q         <= 1'b0;
		end else begin
			rv_s1 <= issue;
			if (issue)
				sc_q <= sc_q + ICW'(1);
			case (state_q)
				ST_IDLE: begin
					si_q   <= '0;
					n_q    <= '0;
					any_q  <= 1'b0;
					hole_q <= 1'b0;
					gap_q  <= 1'b0;
					sc_q   <= '0;
					hit_q  <= 1'b0;
					free_q <= 1'b0;
					if (acc) begin
						if (!rec_q && !in.from_snapshot && in.seq_num == exp_q) begin
							exp_q <= exp_q + 32'd1;
						end else if (rec_q || !in.from_snapshot) begin
							rec_q <= 1'b1;
							if (!rec_q)
								inc_valid_q <= '0;
							if (in.from_snapshot) begin
								state_q <= ST_SSCAN;
								if (in.seq_num >= 32'(SNAP_DEPTH)) begin
									ovf_q <= 1'b1;
								end else begin
									// a repeated number restarts the snapshot
									snap_valid_q <= (snap_valid_q[in.seq_num[SAW-1:0]] ?
										'0 : snap_valid_q) |
										(SNAP_DEPTH'(1) << in.seq_num[SAW-1:0]);
								end
							end else begin
								if (!rec_q)
									snap_valid_q <= '0;
								state_q <= ST_IFIND;
							end
						end
					end
				end
				ST_IFIND: begin
					if (ev && inc_rd_q.tag == item_q.seq_num)
						hit_q <= 1'b1;
					if (rv_s1 && !inc_valid_q[ridx_s1])
						free_q <= 1'b1;
					if (scan_end)
						state_q <= ST_IWR;
				end
				ST_IWR: begin
					if (hit_q)
						inc_valid_q[slot_q] <= 1'b1;
					else if (free_q)
						inc_valid_q[fslot_q] <= 1'b1;
					else
						ovf_q <= 1'b1;
					state_q <= ST_SSCAN;
				end
				ST_SSCAN: begin
					if (snap_valid_q[si_q[SAW-1:0]]) begin
						any_q <= 1'b1;
						if (hole_q)
							gap_q <= 1'b1;
						else
							n_q <= n_q + SCW'(1);
					end else begin
						hole_q <= 1'b1;
					end
					si_q <= si_q + SCW'(1);
					if (si_q == SCW'(SNAP_DEPTH - 1))
						state_q <= ST_SRD0;
				end
				ST_SRD0: begin
					if (!any_q) begin
						state_q <= ST_IDLE;
					end else if (!snap_valid_q[0]) begin
						snap_valid_q <= '0;
						state_q      <= ST_IDLE;
					end else begin
						state_q <= ST_SCHK0;
					end
				end
				ST_SCHK0: begin
					if (snap_rd_q.msg_type != start_code_q || gap_q) begin
						snap_valid_q <= '0;
						state_q      <= ST_IDLE;
					end else begin
						state_q <= ST_SCHKN;
					end
				end
				ST_SCHKN: begin
					// no end marker yet: keep buffering
					if (snap_rd_q.msg_type != end_code_q) begin
						state_q <= ST_IDLE;
					end else begin
						next_q  <= snap_rd_q.ord_ref;
						start_q <= snap_rd_q.ord_ref;
						nsel_q  <= '0;
						eq_q    <= 1'b0;
						eqm_q   <= 1'b0;
						gt_q    <= 1'b0;
						sc_q    <= '0;
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (ev && inc_rd_q.tag == next_q) begin
						eq_q  <= 1'b1;
						eqm_q <= is_marker(inc_rd_q.msg_type, start_code_q, end_code_q);
					end
					if (ev && inc_rd_q.tag > next_q)
						gt_q <= 1'b1;
					if (scan_end)
						state_q <= ST_WDEC;
				end
				ST_WDEC: begin
					eq_q  <= 1'b0;
					eqm_q <= 1'b0;
					gt_q  <= 1'b0;
					ri_q  <= '0;
					if (eq_q && !eqm_q) begin
						nsel_q <= nsel_q + ICW'(1);
						next_q <= next_q + 32'd1;
						sc_q   <= '0;
						// past the top tag nothing can follow
						state_q <= (next_q == '1) ? ST_RSRD : ST_WALK;
					end else if (gt_q) begin
						exp_q        <= next_q;
						snap_valid_q <= '0;
						state_q      <= ST_IDLE;
					end else begin
						state_q <= ST_RSRD;
					end
				end
				ST_RSRD: begin
					if (ri_q == n_q) begin
						rnext_q <= start_q;
						sc_q    <= '0;
						state_q <= (nsel_q == '0) ? ST_FIN : ST_RINC;
					end else begin
						state_q <= ST_RSCHK;
					end
				end
				ST_RSCHK: begin
					if (!oreq.push || oready) begin
						ri_q    <= ri_q + SCW'(1);
						state_q <= ST_RSRD;
					end
				end
				ST_RINC: begin
					if (scan_end)
						state_q <= ST_RIPUSH;
				end
				ST_RIPUSH: begin
					if (oready) begin
						rnext_q <= rnext_q + 32'd1;
						nsel_q  <= nsel_q - ICW'(1);
						sc_q    <= '0;
						state_q <= (nsel_q == ICW'(1)) ? ST_FIN : ST_RINC;
					end
				end
				ST_FIN: begin
					if (oready) begin
						snap_valid_q <= '0;
						inc_valid_q  <= '0;
						rec_q        <= 1'b0;
						exp_q        <= next_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cfg_we) begin
				case (cfg_index)
					CFG_START_SEQ:  exp_q        <= cfg_data;
					CFG_START_CODE: start_code_q <= cfg_data[3:0];
					CFG_END_CODE:   end_code_q   <= cfg_data[3:0];
					default: begin
					end
				endcase
			end
		end
	end

	// stores are empty whenever the feed is live
	a_live_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!rec_q |-> (snap_valid_q == '0 && inc_valid_q == '0))
		else $error("stores hold entries outside recovery");

	a_leave_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(rec_q) |-> $past(state_q) == ST_FIN)
		else $error("recovery left outside the finish step");

	a_replay_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RINC || state_q == ST_RIPUSH) |-> nsel_q != '0)
		else $error("incremental replay with no selected entries");

	a_sticky_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		$past(ovf_q) |-> ovf_q)
		else $error("overflow flag cleared");

endmodule

`default_nettype wire

### test/tb_feed_gap_snapshot_recovery_core.sv
// ----------------------------------------------------------------------------
// tb_feed_gap_snapshot_recovery_core
// Self-checking bench for the feed gap detector with snapshot recovery.
// A directed table covers live forwarding, gaps, snapshot ordering faults,
// overflow and replay; random traffic follows, mixing live bursts, complete
// recovery runs and noise, under several idle/stall phases and marker-code settings.
// Every output beat is compared with a cycle-free software model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_feed_gap_snapshot_recovery_core;
	import fgsr_pkg::*;

	localparam int SDEP = 32;
	localparam int IDEP = 32;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_t         msg = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_t        out;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = CFG_START_SEQ;
	logic [31:0] cfg_data = '0;

	feed_gap_snapshot_recovery_core #(.SNAP_DEPTH(SDEP), .INC_DEPTH(IDEP)) u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in(msg),
		.out_valid(out_valid), .out_stall(out_stall), .out(out),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// model state
	logic [3:0]  m_start_code = START_CODE_RST;
	logic [3:0]  m_end_code = END_CODE_RST;
	bit          m_recov = 0;
	logic [31:0] m_exp_seq = START_SEQ_RST;
	bit          m_ovf = 0;
	bit          snp_v [SDEP];
	snap_ent_t   snp_e [SDEP];
	bit          inc_v [IDEP];
	inc_ent_t    inc_e [IDEP];
	bit          hold_pred = 0;

	out_t        updates_due[$];
	int          mismatches = 0;
	int          tx_pct = 0;
	int          rx_pct = 0;

	function automatic bit is_mark(logic [3:0] t);
		return t == m_start_code || t == m_end_code;
	endfunction

	function automatic void clear_snaps();
		foreach (snp_v[i]) snp_v[i] = 0;
	endfunction

	function automatic void clear_incs();
		foreach (inc_v[i]) inc_v[i] = 0;
	endfunction

	function automatic void store_msg(in_t m);
		int slot;
		slot = -1;
		if (m.from_snapshot) begin
			if (m.seq_num >= SDEP) begin
				m_ovf = 1;
				return;
			end
			if (snp_v[m.seq_num]) clear_snaps();
			snp_v[m.seq_num] = 1;
			snp_e[m.seq_num] = '{m.msg_type, m.ord_ref, m.payload};
			return;
		end
		for (int i = 0; i < IDEP; i++)
			if (slot < 0 && inc_v[i] && inc_e[i].tag == m.seq_num) slot = i;
		for (int i = 0; i < IDEP; i++)
			if (slot < 0 && !inc_v[i]) slot = i;
		if (slot < 0) begin
			m_ovf = 1;
			return;
		end
		inc_v[slot] = 1;
		inc_e[slot] = '{m.seq_num, m.msg_type, m.ord_ref, m.payload};
	endfunction

	function automatic void check_recovery();
		int low, n, cnt, nsel, tmp;
		int idx [IDEP];
		int sel [IDEP];
		logic [31:0] nxt;
		out_t run[$];
		out_t r;
		low = -1;
		for (int i = SDEP - 1; i >= 0; i--)
			if (snp_v[i]) low = i;
		if (low < 0) return;
		if (snp_e[low].msg_type != m_start_code) begin
			clear_snaps();
			return;
		end
		n = 0;
		while (n < SDEP && snp_v[n]) n++;
		for (int i = n; i < SDEP; i++)
			if (snp_v[i]) begin
				clear_snaps();
				return;
			end
		if (snp_e[n-1].msg_type != m_end_code) return;
		nxt = snp_e[n-1].ord_ref;
		cnt = 0;
		for (int i = 0; i < IDEP; i++)
			if (inc_v[i]) begin
				idx[cnt] = i;
				cnt++;
			end
		for (int a = 0; a < cnt; a++)
			for (int b = 0; b + 1 < cnt - a; b++)
				if (inc_e[idx[b]].tag > inc_e[idx[b+1]].tag) begin
					tmp = idx[b];
					idx[b] = idx[b+1];
					idx[b+1] = tmp;
				end
		nsel = 0;
		for (int i = 0; i < cnt; i++) begin
			if (inc_e[idx[i]].tag < nxt) continue;
			if (inc_e[idx[i]].tag != nxt) begin
				m_exp_seq = nxt;
				clear_snaps();
				return;
			end
			if (!is_mark(inc_e[idx[i]].msg_type)) begin
				sel[nsel] = idx[i];
				nsel++;
				nxt = nxt + 32'd1;
			end
		end
		for (int i = 0; i < n; i++)
			if (!is_mark(snp_e[i].msg_type)) begin
				r = '{snp_e[i].msg_type, snp_e[i].ord_ref, snp_e[i].payload, 1'b1, 1'b0};
				run = {run, r};
			end
		for (int i = 0; i < nsel; i++) begin
			r = '{inc_e[sel[i]].msg_type, inc_e[sel[i]].ord_ref, inc_e[sel[i]].payload,
				1'b1, 1'b0};
			run = {run, r};
		end
		if (run.size() > 0) run[run.size()-1].last_of_run = 1'b1;
		if (!hold_pred)
			updates_due = {updates_due, run};
		clear_snaps();
		clear_incs();
		m_recov = 0;
		m_exp_seq = nxt;
	endfunction

	function automatic void predict_feed(in_t m);
		out_t r;
		if (m.from_snapshot && !m_recov) return;
		if (!m_recov) begin
			if (m.seq_num == m_exp_seq) begin
				m_exp_seq = m_exp_seq + 32'd1;
				r = '{m.msg_type, m.ord_ref, m.payload, 1'b0, 1'b1};
				if (!hold_pred) updates_due = {updates_due, r};
				return;
			end
			m_recov = 1;
			clear_snaps();
			clear_incs();
		end
		store_msg(m);
		check_recovery();
	endfunction

	// output check
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (updates_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: type %h order %h payload %h rep %b last %b",
						out.out_type, out.out_ord_ref, out.out_payload,
						out.from_replay, out.last_of_run);
			end else begin
				if (out !== updates_due[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %h %h %h %b %b got %h %h %h %b %b",
							updates_due[0].out_type, updates_due[0].out_ord_ref,
							updates_due[0].out_payload, updates_due[0].from_replay,
							updates_due[0].last_of_run, out.out_type, out.out_ord_ref,
							out.out_payload, out.from_replay, out.last_of_run);
				end
				void'(updates_due.pop_front());
			end
		end
	end

	always @(negedge clk)
		out_stall <= (rx_pct != 0) && ($urandom_range(0, 99) < rx_pct);

	// called at a falling edge, returns at a falling edge
	task automatic send_msg(input in_t m);
		while (tx_pct != 0 && $urandom_range(0, 99) < tx_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		msg = m;
		do @(posedge clk); while (in_stall);
		predict_feed(m);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			CFG_START_SEQ:  m_exp_seq = val;
			CFG_START_CODE: m_start_code = val[3:0];
			CFG_END_CODE:   m_end_code = val[3:0];
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		while (updates_due.size() != 0) @(negedge clk);
		repeat (2600) @(negedge clk);
	endtask

	function automatic in_t mk(bit s, logic [31:0] sq, logic [3:0] t, logic [31:0] o,
		logic [63:0] p);
		in_t m;
		m = '{s, sq, t, o, p};
		return m;
	endfunction

	function automatic logic [3:0] plain_type();
		logic [3:0] t;
		do t = 4'($urandom_range(0, 15)); while (is_mark(t));
		return t;
	endfunction

	function automatic logic [63:0] rnd64();
		return {$urandom(), $urandom()};
	endfunction

	task automatic send_noise();
		in_t m;
		m = '{1'($urandom_range(0, 1)), $urandom(), 4'($urandom_range(0, 15)), $urandom(),
			rnd64()};
		if ($urandom_range(0, 1)) m.seq_num = $urandom_range(0, 40);
		send_msg(m);
	endtask

	// one gap followed by a complete snapshot and a run of incrementals
	task automatic send_recovery(inout int sent);
		logic [31:0] base;
		int k, n, gap_at, tmp;
		logic [31:0] tags[$];
		logic [31:0] low_tags[$];
		logic [3:0] t;
		base = m_exp_seq + $urandom_range(2, 40);
		k = $urandom_range(0, 6);
		gap_at = ($urandom_range(0, 5) == 0 && k > 1) ? $urandom_range(0, k - 1) : -1;
		for (int i = 0; i < k; i++)
			if (i != gap_at) tags = {tags, base + i};
		if ($urandom_range(0, 3) == 0) tags = {tags, base - $urandom_range(1, 2)};
		for (int i = 0; i < tags.size(); i++) begin
			tmp = $urandom_range(0, tags.size() - 1);
			base = tags[i]; tags[i] = tags[tmp]; tags[tmp] = base;
		end
		if (tags.size() == 0)
			send_msg(mk(1'b0, m_exp_seq + 1, plain_type(), $urandom(), rnd64()));
		foreach (tags[i]) begin
			t = ($urandom_range(0, 7) == 0) ? m_start_code : plain_type();
			send_msg(mk(1'b0, tags[i], t, $urandom(), rnd64()));
			sent++;
		end
		low_tags = tags.min();
		base = (tags.size() == 0) ? m_exp_seq : low_tags[0];
		n = $urandom_range((m_start_code == m_end_code) ? 1 : 2, 6);
		for (int i = 0; i < n; i++) begin
			t = (i == 0) ? m_start_code : (i == n - 1) ? m_end_code : plain_type();
			send_msg(mk(1'b1, i, t, (i == n - 1) ? base : $urandom(), rnd64()));
			sent++;
		end
	endtask

	typedef struct {
		in_t  m;
		bit   typed;
		out_t res;
	} row_t;

	row_t steps[$];

	task automatic add_row(input in_t m, input bit typed = 0, input out_t res = '0);
		row_t r;
		r.m = m;
		r.typed = typed;
		r.res = res;
		steps = {steps, r};
	endtask

	initial begin
		int sent, pick, burst;
		logic [31:0] sseq [5];
		logic [3:0]  scode [5];
		logic [3:0]  ecode [5];

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table, reset codes: start 1, end 2
		add_row(mk(1'b0, 32'd0, 4'hf, 32'hffff_ffff, '1), 1,
			'{4'hf, 32'hffff_ffff, '1, 1'b0, 1'b1});
		add_row(mk(1'b0, 32'd1, 4'h0, 32'd0, 64'd0), 1, '{4'h0, 32'd0, 64'd0, 1'b0, 1'b1});
		add_row(mk(1'b1, 32'd0, 4'h1, 32'd3, 64'd5), 1, '0);      // snapshot while live
		add_row(mk(1'b0, 32'd5, 4'h3, 32'ha, 64'h11));            // gap
		add_row(mk(1'b0, 32'd6, 4'h4, 32'hb, 64'h22));
		add_row(mk(1'b0, 32'd3, 4'h5, 32'hc, 64'h33));            // stale, skipped
		add_row(mk(1'b0, 32'd7, 4'h1, 32'hd, 64'h44));            // marker type, not replayed
		add_row(mk(1'b1, 32'd40, 4'h1, 32'd0, 64'd0));            // beyond store
		add_row(mk(1'b1, 32'd0, 4'h1, 32'h99, 64'h55));
		add_row(mk(1'b1, 32'd1, 4'h9, 32'h77, '1));
		add_row(mk(1'b1, 32'd2, 4'h2, 32'd5, 64'h66));            // end marker: replay
		add_row(mk(1'b0, 32'd7, 4'h8, 32'h1, 64'h1));
		add_row(mk(1'b0, 32'd20, 4'h6, 32'h2, 64'h2));            // gap
		add_row(mk(1'b1, 32'd1, 4'h5, 32'h3, 64'h3));             // lowest not a start
		add_row(mk(1'b1, 32'd0, 4'h1, 32'h4, 64'h4));
		add_row(mk(1'b1, 32'd2, 4'h9, 32'h5, 64'h5));             // hole in snapshot
		add_row(mk(1'b1, 32'd0, 4'h1, 32'h6, 64'h6));
		add_row(mk(1'b1, 32'd0, 4'h1, 32'h7, 64'h7));             // repeated number
		add_row(mk(1'b1, 32'd1, 4'h2, 32'd19, 64'h8));            // incremental gap
		add_row(mk(1'b1, 32'd0, 4'h1, 32'h9, 64'h9));
		add_row(mk(1'b1, 32'd1, 4'h6, 32'ha, 64'ha));
		add_row(mk(1'b1, 32'd2, 4'h2, 32'd20, 64'hb));
		add_row(mk(1'b0, 32'd21, 4'h7, 32'hffff_ffff, 64'h8000_0000_0000_0000));
		foreach (steps[i]) begin
			hold_pred = steps[i].typed;
			send_msg(steps[i].m);
			hold_pred = 0;
			if (steps[i].typed && steps[i].res.last_of_run)
				updates_due = {updates_due, steps[i].res};
		end

		sseq  = '{$urandom(), 32'hffff_ffff, 32'd0, $urandom(), 32'hffff_fff0};
		scode = '{4'd1, 4'd0, 4'd15, 4'd3, 4'd7};
		ecode = '{4'd2, 4'd15, 4'd0, 4'd3, 4'd9};
		sent = 0;
		for (int ph = 0; ph < 5; ph++) begin
			tx_pct = 0;
			rx_pct = 0;
			wait_idle();
			cfg_write(CFG_START_SEQ, sseq[ph]);
			cfg_write(CFG_START_CODE, {28'd0, scode[ph]});
			cfg_write(CFG_END_CODE, {28'd0, ecode[ph]});
			case (ph % 4)
				1: tx_pct = 51;
				2: rx_pct = 51;
				3: begin
					tx_pct = 25;
					rx_pct = 25;
				end
				default: ;
			endcase
			while (sent < 60 * (ph + 1)) begin
				pick = $urandom_range(0, 9);
				if (pick < 4) begin
					burst = $urandom_range(1, 5);
					repeat (burst) begin
						send_msg(mk(1'b0, m_exp_seq, 4'($urandom_range(0, 15)), $urandom(),
							rnd64()));
						sent++;
					end
				end else if (pick < 8) begin
					send_recovery(sent);
				end else begin
					send_noise();
					sent++;
				end
			end
		end

		while (updates_due.size() != 0) @(negedge clk);
		repeat (2600) @(negedge clk);
		if (mismatches == 0 && updates_due.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#80ms;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
